>>> src/script_token_scanner_unit_macros.svh
// ---------------------------------------------------------------------------
// script_token_scanner_unit_macros.svh
// Assertion macros for the token scanner.
// ---------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_SCANNER_UNIT_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_UNIT_MACROS_SVH
`ifndef SYNTH
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/sts_pkg.sv
// ---------------------------------------------------------------------------
// sts_pkg
// Shared types, token codes and character helpers of the token scanner.
// ---------------------------------------------------------------------------
package sts_pkg;

  localparam int POS_WIDTH_DEF = 32;
  localparam int MAX_RES       = 3;

  typedef logic [5:0] kind_t;

  localparam kind_t K_EOF        = 6'd0;
  localparam kind_t K_ERR_CHAR   = 6'd1;
  localparam kind_t K_ERR_UNTERM = 6'd2;
  localparam kind_t K_ERR_NUM    = 6'd3;
  localparam kind_t K_LBRACK     = 6'd4;
  localparam kind_t K_RBRACK     = 6'd5;
  localparam kind_t K_LPAREN     = 6'd6;
  localparam kind_t K_RPAREN     = 6'd7;
  localparam kind_t K_LBRACE     = 6'd8;
  localparam kind_t K_RBRACE     = 6'd9;
  localparam kind_t K_PERIOD     = 6'd10;
  localparam kind_t K_PERIOD2    = 6'd11;
  localparam kind_t K_PERIOD3    = 6'd12;
  localparam kind_t K_COMMA      = 6'd13;
  localparam kind_t K_COLON      = 6'd14;
  localparam kind_t K_SEMI       = 6'd15;
  localparam kind_t K_PLUS       = 6'd16;
  localparam kind_t K_MINUS      = 6'd18;
  localparam kind_t K_STAR       = 6'd20;
  localparam kind_t K_SLASH      = 6'd22;
  localparam kind_t K_PERCENT    = 6'd24;
  localparam kind_t K_LT         = 6'd26;
  localparam kind_t K_GT         = 6'd28;
  localparam kind_t K_BANG       = 6'd30;
  localparam kind_t K_ASSIGN     = 6'd32;
  localparam kind_t K_NONE       = 6'd0;
  localparam kind_t K_NEWLINE    = 6'd34;
  localparam kind_t K_STRING     = 6'd35;
  localparam kind_t K_INTEGER    = 6'd36;
  localparam kind_t K_DECIMAL    = 6'd37;
  localparam kind_t K_IDENT      = 6'd38;
  localparam kind_t K_STRBYTE    = 6'd39;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // scan modes, one-hot
  typedef enum logic [10:0] {
    M_IDLE    = 11'b000_0000_0001,
    M_COMMENT = 11'b000_0000_0010,
    M_DOT1    = 11'b000_0000_0100,
    M_DOT2    = 11'b000_0000_1000,
    M_OP      = 11'b000_0001_0000,
    M_INT     = 11'b000_0010_0000,
    M_INTDOT  = 11'b000_0100_0000,
    M_DEC     = 11'b000_1000_0000,
    M_IDENT   = 11'b001_0000_0000,
    M_STR     = 11'b010_0000_0000,
    M_STRESC  = 11'b100_0000_0000
  } mode_t;

  // one result: offsets already cut to 32 bits
  typedef struct packed {
    kind_t       kind;
    logic [31:0] start_off;
    logic [31:0] end_off;
    logic [31:0] line;
    logic [7:0]  sbyte;
  } res_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a)) ||
           (b == 8'h5f);
  endfunction

  // single-character kind of an operator that may take '='
  function automatic kind_t op_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      8'h2b:   k = K_PLUS;
      8'h2d:   k = K_MINUS;
      8'h2a:   k = K_STAR;
      8'h2f:   k = K_SLASH;
      8'h25:   k = K_PERCENT;
      8'h3c:   k = K_LT;
      8'h3e:   k = K_GT;
      8'h21:   k = K_BANG;
      8'h3d:   k = K_ASSIGN;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // single-byte punctuation kind (K_NONE if not)
  function automatic kind_t punct_kind(input logic [7:0] b);
    kind_t k;
    case (b)
      8'h5b:   k = K_LBRACK;
      8'h5d:   k = K_RBRACK;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7b:   k = K_LBRACE;
      8'h7d:   k = K_RBRACE;
      8'h2c:   k = K_COMMA;
      8'h3a:   k = K_COLON;
      8'h3b:   k = K_SEMI;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // escape decode: bit 8 set when the letter is a known escape
  function automatic logic [8:0] esc_val(input logic [7:0] b);
    logic [8:0] v;
    case (b)
      8'h22:   v = {1'b1, 8'h22};
      8'h5c:   v = {1'b1, 8'h5c};
      8'h25:   v = {1'b1, 8'h25};
      8'h30:   v = {1'b1, 8'h00};
      8'h61:   v = {1'b1, 8'h07};
      8'h62:   v = {1'b1, 8'h08};
      8'h66:   v = {1'b1, 8'h0c};
      8'h6e:   v = {1'b1, 8'h0a};
      8'h72:   v = {1'b1, 8'h0d};
      8'h74:   v = {1'b1, 8'h09};
      8'h76:   v = {1'b1, 8'h0b};
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/script_token_scanner_unit.sv
// ---------------------------------------------------------------------------
// script_token_scanner_unit
// Byte-serial lexical scanner: source words in, token words out.
// ---------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser | tlast
// in_     | in  | source_byte                             | op    | -
// out_    | out | kind, start, end, line, string byte     | -     | last
//
// A word without results does not load the output register; one that gives k results
// holds it until all k have left, one result per cycle while the output is ready.
// Scan state updates in the cycle the word is accepted; results show the next.
// Reset (rst_n low, synchronous) returns the scanner to idle at line one.
// Input stalls while results are pending and is taken again in the cycle the
// final result of the previous word leaves.
`include "script_token_scanner_unit_macros.svh"
module script_token_scanner_unit #(
  parameter int POS_WIDTH = sts_pkg::POS_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] source_byte
  input  logic         in_tuser,   // [0] op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // [5:0] kind, [37:6] start, [69:38] end,
                                   // [101:70] line, [109:102] string byte
  output logic         out_tlast
);

  sts_pkg::res_t [sts_pkg::MAX_RES-1:0] res;
  sts_pkg::res_t                        ores;
  logic [1:0] res_cnt;
  logic       res_any, can_load, step;

  // a word is taken when the result register can take its results
  assign in_tready = can_load;
  assign step      = in_tvalid && in_tready;

  sts_core #(.POS_WIDTH(POS_WIDTH)) u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .op(in_tuser), .sbyte(in_tdata),
    .res_cnt(res_cnt), .res_any(res_any), .res(res)
  );

  sts_outq u_outq (
    .clk(clk), .rst_n(rst_n), .load(step && res_any), .load_cnt(res_cnt),
    .load_res(res), .can_load(can_load), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_res(ores), .out_last(out_tlast)
  );

  assign out_tdata = {2'b00, ores.sbyte, ores.line, ores.end_off, ores.start_off,
                      ores.kind};

  `STS_ASSERT_IMPL(a_ready_when_idle, clk, rst_n, !out_tvalid, in_tready)
  `STS_ASSERT_NEXT(a_end_gives_result, clk, rst_n, in_tvalid && in_tready && in_tuser, out_tvalid)
  `STS_ASSERT_IMPL(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[111:110] == 2'b00)

endmodule

>>> src/sts_core.sv
// ---------------------------------------------------------------------------
// sts_core
// Scan state and next-state logic: one source word in, up to three results.
// ---------------------------------------------------------------------------
module sts_core #(
  parameter int POS_WIDTH = sts_pkg::POS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,      // take one word
  input  logic                              op,
  input  logic [7:0]                        sbyte,
  output logic [1:0]                        res_cnt,   // results minus one
  output logic                              res_any,
  output sts_pkg::res_t [sts_pkg::MAX_RES-1:0] res
);

  sts_pkg::mode_t       mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] tstart_r, tstart_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [31:0]          line_r, line_nxt;
  logic [7:0]           held_r, held_nxt;

  always_comb begin
    logic [POS_WIDTH-1:0] p, p1, pm1, ts;
    logic [31:0]          p32, p1_32, pm1_32, ts32;
    logic [31:0]          ln;
    logic [1:0]           n;
    logic                 go_idle;
    logic [8:0]           ev;
    sts_pkg::kind_t       pk;
    sts_pkg::mode_t       md;

    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    pos_nxt    = pos_r;
    line_nxt   = line_r;
    held_nxt   = held_r;
    res        = '0;
    n          = 2'd0;
    go_idle    = 1'b0;
    p          = pos_r;
    p1         = pos_r + POS_WIDTH'(1);
    pm1        = pos_r - POS_WIDTH'(1);
    ts         = tstart_r;
    p32        = 32'(p);
    p1_32      = 32'(p1);
    pm1_32     = 32'(pm1);
    ts32       = 32'(ts);
    ln         = line_r;
    ev         = sts_pkg::esc_val(sbyte);
    pk         = sts_pkg::punct_kind(sbyte);
    md         = mode_r;
    // results carry the line count as it stands before this word, but for a newline string byte
    for (int i = 0; i < sts_pkg::MAX_RES; i++) res[i].line = line_r;

    if (op == sts_pkg::OP_END) begin
      // flush the pending token, then eof
      case (mode_r)
        sts_pkg::M_DOT1, sts_pkg::M_DOT2, sts_pkg::M_OP, sts_pkg::M_INT,
        sts_pkg::M_DEC, sts_pkg::M_IDENT, sts_pkg::M_STR: begin
          res[0].kind = (mode_r == sts_pkg::M_DOT1)  ? sts_pkg::K_PERIOD :
                        (mode_r == sts_pkg::M_DOT2)  ? sts_pkg::K_PERIOD2 :
                        (mode_r == sts_pkg::M_OP)    ? sts_pkg::op_kind(held_r) :
                        (mode_r == sts_pkg::M_INT)   ? sts_pkg::K_INTEGER :
                        (mode_r == sts_pkg::M_DEC)   ? sts_pkg::K_DECIMAL :
                        (mode_r == sts_pkg::M_IDENT) ? sts_pkg::K_IDENT :
                                                       sts_pkg::K_ERR_UNTERM;
          res[0].start_off = ts32;
          res[0].end_off   = p32;
          n = 2'd1;
        end
        sts_pkg::M_INTDOT: begin
          res[0].kind = sts_pkg::K_INTEGER;
          res[0].start_off = ts32;
          res[0].end_off   = pm1_32;
          res[1].kind = sts_pkg::K_PERIOD;
          res[1].start_off = pm1_32;
          res[1].end_off   = p32;
          n = 2'd2;
        end
        sts_pkg::M_STRESC: begin
          res[0].kind = sts_pkg::K_STRBYTE;
          res[0].start_off = pm1_32;
          res[0].end_off   = p32;
          res[0].sbyte     = 8'h5c;
          res[1].kind = sts_pkg::K_ERR_UNTERM;
          res[1].start_off = ts32;
          res[1].end_off   = p32;
          n = 2'd2;
        end
        default: n = 2'd0;
      endcase
      res[n].kind      = sts_pkg::K_EOF;
      res[n].start_off = p32;
      res[n].end_off   = p32;
      n = n + 2'd1;
      mode_nxt   = sts_pkg::M_IDLE;
      tstart_nxt = p;
    end else begin
      pos_nxt = p1;
      // pass one: finish the pending token, decide whether the byte restarts
      case (mode_r)
        sts_pkg::M_COMMENT: go_idle = (sbyte == 8'h0a);
        sts_pkg::M_DOT1, sts_pkg::M_DOT2: begin
          if (sbyte == 8'h2e) begin
            if (mode_r == sts_pkg::M_DOT1) md = sts_pkg::M_DOT2;
            else begin
              res[0].kind = sts_pkg::K_PERIOD3;
              res[0].start_off = ts32;
              res[0].end_off = p1_32;
              n = 2'd1;
              md = sts_pkg::M_IDLE;
            end
          end else begin
            res[0].kind = (mode_r == sts_pkg::M_DOT1) ? sts_pkg::K_PERIOD
                                                      : sts_pkg::K_PERIOD2;
            res[0].start_off = ts32;
            res[0].end_off = p32;
            n = 2'd1;
            go_idle = 1'b1;
          end
        end
        sts_pkg::M_OP: begin
          res[0].start_off = ts32;
          n = 2'd1;
          if (sbyte == 8'h3d) begin
            res[0].kind = sts_pkg::op_kind(held_r) + 6'd1;
            res[0].end_off = p1_32;
            md = sts_pkg::M_IDLE;
          end else begin
            res[0].kind = sts_pkg::op_kind(held_r);
            res[0].end_off = p32;
            go_idle = 1'b1;
          end
        end
        sts_pkg::M_INT, sts_pkg::M_DEC: begin
          if (sts_pkg::is_digit(sbyte)) md = mode_r;
          else if (mode_r == sts_pkg::M_INT && sbyte == 8'h2e) md = sts_pkg::M_INTDOT;
          else begin
            res[0].kind = sts_pkg::is_letter(sbyte) ? sts_pkg::K_ERR_NUM :
                          (mode_r == sts_pkg::M_INT) ? sts_pkg::K_INTEGER :
                                                       sts_pkg::K_DECIMAL;
            res[0].start_off = ts32;
            res[0].end_off = p32;
            n = 2'd1;
            go_idle = 1'b1;
          end
        end
        sts_pkg::M_INTDOT: begin
          if (sts_pkg::is_digit(sbyte)) md = sts_pkg::M_DEC;
          else begin
            res[0].kind = sts_pkg::K_INTEGER;
            res[0].start_off = ts32;
            res[0].end_off = pm1_32;
            n = 2'd1;
            tstart_nxt = pm1;
            if (sbyte == 8'h2e) md = sts_pkg::M_DOT2;
            else begin
              res[1].kind = sts_pkg::K_PERIOD;
              res[1].start_off = pm1_32;
              res[1].end_off = p32;
              n = 2'd2;
              go_idle = 1'b1;
            end
          end
        end
        sts_pkg::M_IDENT: begin
          if (!(sts_pkg::is_letter(sbyte) || sts_pkg::is_digit(sbyte))) begin
            res[0].kind = sts_pkg::K_IDENT;
            res[0].start_off = ts32;
            res[0].end_off = p32;
            n = 2'd1;
            go_idle = 1'b1;
          end
        end
        sts_pkg::M_STR, sts_pkg::M_STRESC: begin
          if (mode_r == sts_pkg::M_STRESC && ev[8]) begin
            res[0].kind = sts_pkg::K_STRBYTE;
            res[0].start_off = pm1_32;
            res[0].end_off = p1_32;
            res[0].sbyte = ev[7:0];
            n = 2'd1;
            md = sts_pkg::M_STR;
          end else begin
            if (mode_r == sts_pkg::M_STRESC) begin
              res[0].kind = sts_pkg::K_STRBYTE;
              res[0].start_off = pm1_32;
              res[0].end_off = p32;
              res[0].sbyte = 8'h5c;
              n = 2'd1;
            end
            if (sbyte == 8'h22) begin
              res[n].kind = sts_pkg::K_STRING;
              res[n].start_off = ts32;
              res[n].end_off = p1_32;
              n = n + 2'd1;
              md = sts_pkg::M_IDLE;
            end else if (sbyte == 8'h5c) begin
              md = sts_pkg::M_STRESC;
            end else begin
              md = sts_pkg::M_STR;
              // a newline byte already counts toward its own line
              if (sbyte == 8'h0a) ln = line_r + 32'd1;
              res[n].kind = sts_pkg::K_STRBYTE;
              res[n].start_off = p32;
              res[n].end_off = p1_32;
              res[n].line = ln;
              res[n].sbyte = sbyte;
              n = n + 2'd1;
            end
          end
        end
        default: go_idle = 1'b1;
      endcase
      // pass two: byte seen from idle
      if (go_idle) begin
        tstart_nxt = p;
        md = sts_pkg::M_IDLE;
        if (sbyte == 8'h20 || sbyte == 8'h0d || sbyte == 8'h09) md = sts_pkg::M_IDLE;
        else if (sts_pkg::is_digit(sbyte)) md = sts_pkg::M_INT;
        else if (sts_pkg::is_letter(sbyte)) md = sts_pkg::M_IDENT;
        else if (sts_pkg::op_kind(sbyte) != sts_pkg::K_NONE) begin
          md = sts_pkg::M_OP;
          held_nxt = sbyte;
        end else if (sbyte == 8'h23) md = sts_pkg::M_COMMENT;
        else if (sbyte == 8'h2e) md = sts_pkg::M_DOT1;
        else if (sbyte == 8'h22) md = sts_pkg::M_STR;
        else begin
          res[n].kind = (pk != sts_pkg::K_NONE) ? pk :
                        (sbyte == 8'h0a) ? sts_pkg::K_NEWLINE : sts_pkg::K_ERR_CHAR;
          res[n].start_off = p32;
          res[n].end_off = p1_32;
          n = n + 2'd1;
          if (sbyte == 8'h0a) ln = line_r + 32'd1;
        end
      end
      mode_nxt = md;
    end
    line_nxt = ln;
    res_any  = (n != 2'd0);
    res_cnt  = n - 2'd1;
  end

  // advance the scan state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sts_pkg::M_IDLE;
      tstart_r <= '0;
      pos_r    <= '0;
      line_r   <= 32'd1;
      held_r   <= 8'd0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      tstart_r <= tstart_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

>>> src/sts_outq.sv
// ---------------------------------------------------------------------------
// sts_outq
// Result register: holds up to three results of one word, sends one a cycle while out_ready is high.
// ---------------------------------------------------------------------------
module sts_outq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  logic [1:0]                           load_cnt,
  input  sts_pkg::res_t [sts_pkg::MAX_RES-1:0] load_res,
  output logic                                 can_load,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sts_pkg::res_t                        out_res,
  output logic                                 out_last
);

  sts_pkg::res_t [sts_pkg::MAX_RES-1:0] buf_r;
  logic [1:0] rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       vld_r, vld_nxt;
  logic       pop;

  assign out_valid = vld_r;
  assign out_res   = buf_r[rd_r];
  assign out_last  = (rd_r == cnt_r);
  assign pop       = vld_r && out_ready;
  // accept a new word once the final result leaves
  assign can_load  = !vld_r || (pop && out_last);

  always_comb begin
    vld_nxt = vld_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      if (out_last) vld_nxt = 1'b0;
      else rd_nxt = rd_r + 2'd1;
    end
    if (load && can_load) begin
      vld_nxt = 1'b1;
      rd_nxt  = 2'd0;
      cnt_nxt = load_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rd_r  <= 2'd0;
      cnt_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (load && can_load) buf_r <= load_res;
  end

endmodule

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// Token scanner testbench
// Streams source bytes and end markers into the scanner, predicts every
// token word with a behavioral scanner model and checks the output stream.
// ---------------------------------------------------------------------------
module testbench;
  import sts_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    kind_t       kind;
    logic [31:0] start_off;
    logic [31:0] end_off;
    logic [31:0] line;
    logic [7:0]  sbyte;
    logic        last;
  } token_word_t;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       has_exp;
    kind_t      exp_kind;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'd0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         out_tlast;

  // scanner model state
  mode_t       sc_mode;
  logic [31:0] sc_start;
  logic [31:0] sc_pos;
  logic [31:0] sc_line;
  logic [7:0]  sc_held;

  token_word_t pending_tokens[$];
  token_word_t step_words[$];
  int          errors = 0;
  int          cycles = 0;
  bit          hold_start = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_cnt = 0;

  script_token_scanner_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  function automatic bit digit_b(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit letter_b(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic kind_t oper_kind(logic [7:0] b);
    case (b)
      "+": return K_PLUS;
      "-": return K_MINUS;
      "*": return K_STAR;
      "/": return K_SLASH;
      "%": return K_PERCENT;
      "<": return K_LT;
      ">": return K_GT;
      "!": return K_BANG;
      "=": return K_ASSIGN;
      default: return K_NONE;
    endcase
  endfunction

  task automatic emit(kind_t k, logic [31:0] s, logic [31:0] e, logic [7:0] sb);
    token_word_t w;
    w.kind = k; w.start_off = s; w.end_off = e; w.line = sc_line;
    w.sbyte = sb; w.last = 1'b0;
    step_words = {step_words, w};
  endtask

  task automatic scan_idle(logic [7:0] b, logic [31:0] p);
    logic [31:0] e;
    e = p + 32'd1;
    sc_start = p;
    sc_mode = M_IDLE;
    if (b == " " || b == 8'h0d || b == 8'h09) return;
    if (digit_b(b)) begin sc_mode = M_INT; return; end
    if (letter_b(b)) begin sc_mode = M_IDENT; return; end
    if (oper_kind(b) != K_NONE) begin
      sc_mode = M_OP; sc_held = b; return;
    end
    case (b)
      "#": sc_mode = M_COMMENT;
      ".": sc_mode = M_DOT1;
      8'h22: sc_mode = M_STR;
      "[": emit(K_LBRACK, p, e, 8'd0);
      "]": emit(K_RBRACK, p, e, 8'd0);
      "(": emit(K_LPAREN, p, e, 8'd0);
      ")": emit(K_RPAREN, p, e, 8'd0);
      "{": emit(K_LBRACE, p, e, 8'd0);
      "}": emit(K_RBRACE, p, e, 8'd0);
      ",": emit(K_COMMA, p, e, 8'd0);
      ":": emit(K_COLON, p, e, 8'd0);
      ";": emit(K_SEMI, p, e, 8'd0);
      8'h0a: begin
        emit(K_NEWLINE, p, e, 8'd0);
        sc_line = sc_line + 32'd1;
      end
      default: emit(K_ERR_CHAR, p, e, 8'd0);
    endcase
  endtask

  task automatic scan_string(logic [7:0] b, logic [31:0] p);
    if (b == 8'h22) begin
      sc_mode = M_IDLE;
      emit(K_STRING, sc_start, p + 32'd1, 8'd0);
    end else if (b == 8'h5c) begin
      sc_mode = M_STRESC;
    end else begin
      sc_mode = M_STR;
      if (b == 8'h0a) sc_line = sc_line + 32'd1;
      emit(K_STRBYTE, p, p + 32'd1, b);
    end
  endtask

  task automatic scan_dot1(logic [7:0] b, logic [31:0] p);
    if (b == ".") sc_mode = M_DOT2;
    else begin
      emit(K_PERIOD, sc_start, p, 8'd0);
      scan_idle(b, p);
    end
  endtask

  function automatic int escape_code(logic [7:0] b);
    case (b)
      8'h22: return 8'h22;
      8'h5c: return 8'h5c;
      "%": return "%";
      "0": return 0;
      "a": return 7;
      "b": return 8;
      "f": return 12;
      "n": return 10;
      "r": return 13;
      "t": return 9;
      "v": return 11;
      default: return -1;
    endcase
  endfunction

  // compute the words one input word causes and queue them as expected
  task automatic predict_tokens(logic op, logic [7:0] b);
    logic [31:0] p;
    int v;
    step_words.delete();
    p = sc_pos;
    if (op == OP_END) begin
      case (sc_mode)
        M_DOT1:  emit(K_PERIOD, sc_start, p, 8'd0);
        M_DOT2:  emit(K_PERIOD2, sc_start, p, 8'd0);
        M_OP:    emit(oper_kind(sc_held), sc_start, p, 8'd0);
        M_INT:   emit(K_INTEGER, sc_start, p, 8'd0);
        M_DEC:   emit(K_DECIMAL, sc_start, p, 8'd0);
        M_IDENT: emit(K_IDENT, sc_start, p, 8'd0);
        M_INTDOT: begin
          emit(K_INTEGER, sc_start, p - 32'd1, 8'd0);
          emit(K_PERIOD, p - 32'd1, p, 8'd0);
        end
        M_STRESC: begin
          emit(K_STRBYTE, p - 32'd1, p, 8'h5c);
          emit(K_ERR_UNTERM, sc_start, p, 8'd0);
        end
        M_STR: emit(K_ERR_UNTERM, sc_start, p, 8'd0);
        default: ;
      endcase
      emit(K_EOF, p, p, 8'd0);
      sc_mode = M_IDLE;
      sc_start = p;
    end else begin
      sc_pos = p + 32'd1;
      case (sc_mode)
        M_COMMENT: if (b == 8'h0a) scan_idle(b, p);
        M_DOT1: scan_dot1(b, p);
        M_DOT2:
          if (b == ".") begin
            sc_mode = M_IDLE;
            emit(K_PERIOD3, sc_start, p + 32'd1, 8'd0);
          end else begin
            emit(K_PERIOD2, sc_start, p, 8'd0);
            scan_idle(b, p);
          end
        M_OP:
          if (b == "=") begin
            sc_mode = M_IDLE;
            emit(kind_t'(oper_kind(sc_held) + 6'd1), sc_start, p + 32'd1, 8'd0);
          end else begin
            emit(oper_kind(sc_held), sc_start, p, 8'd0);
            scan_idle(b, p);
          end
        M_INT, M_DEC:
          if (digit_b(b)) ;
          else if (sc_mode == M_INT && b == ".") sc_mode = M_INTDOT;
          else if (letter_b(b)) begin
            emit(K_ERR_NUM, sc_start, p, 8'd0);
            scan_idle(b, p);
          end else begin
            emit(sc_mode == M_INT ? K_INTEGER : K_DECIMAL, sc_start, p, 8'd0);
            scan_idle(b, p);
          end
        M_INTDOT:
          if (digit_b(b)) sc_mode = M_DEC;
          else begin
            emit(K_INTEGER, sc_start, p - 32'd1, 8'd0);
            sc_start = p - 32'd1;
            sc_mode = M_DOT1;
            scan_dot1(b, p);
          end
        M_IDENT:
          if (!(letter_b(b) || digit_b(b))) begin
            emit(K_IDENT, sc_start, p, 8'd0);
            scan_idle(b, p);
          end
        M_STR: scan_string(b, p);
        M_STRESC: begin
          v = escape_code(b);
          if (v >= 0) begin
            sc_mode = M_STR;
            emit(K_STRBYTE, p - 32'd1, p + 32'd1, v[7:0]);
          end else begin
            emit(K_STRBYTE, p - 32'd1, p, 8'h5c);
            scan_string(b, p);
          end
        end
        default: scan_idle(b, p);
      endcase
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) pending_tokens = {pending_tokens, step_words[i]};
  endtask

  // offer one word and hold it until it is taken
  task automatic send_word(logic op, logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    predict_tokens(op, b);
  endtask

  // send one word, sometimes followed by a gap
  task automatic send_burst(logic op, logic [7:0] b);
    send_word(op, b);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tokens.size() > 0) @(posedge clk);
  endtask

  // random source text, mostly well-formed fragments
  task automatic send_fragment;
    int sel;
    int n;
    string ops;
    string puncts;
    ops = "+-*/%<>!=";
    puncts = "[](){},:; \t\r\n#";
    sel = $urandom_range(0, 9);
    n = $urandom_range(1, 5);
    case (sel)
      0: repeat (n) send_burst(OP_BYTE, 8'("0" + $urandom_range(0, 9)));
      1: repeat (n) send_burst(OP_BYTE, 8'("a" + $urandom_range(0, 25)));
      2: begin
        send_burst(OP_BYTE, 8'h22);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) send_burst(OP_BYTE, 8'h5c);
          send_burst(OP_BYTE, $urandom_range(0, 3) == 0 ?
                     8'($urandom_range(0, 255)) : 8'("a" + $urandom_range(0, 25)));
        end
        if ($urandom_range(0, 4) != 0) send_burst(OP_BYTE, 8'h22);
      end
      3: send_burst(OP_BYTE, ops[$urandom_range(0, 8)]);
      4: send_burst(OP_BYTE, "=");
      5: repeat ($urandom_range(1, 3)) send_burst(OP_BYTE, ".");
      6: send_burst(OP_BYTE, puncts[$urandom_range(0, 14)]);
      7: send_burst(OP_BYTE, 8'($urandom_range(0, 255)));
      8: send_burst(OP_BYTE, 8'h0a);
      default: if ($urandom_range(0, 5) == 0) send_burst(OP_END, 8'($urandom));
    endcase
  endtask

  // directed rows; expected kind typed in where obvious
  stim_row_t rows[] = '{
    '{OP_END,  8'h00, 1'b1, K_EOF},
    '{OP_BYTE, "(",   1'b1, K_LPAREN},
    '{OP_BYTE, 8'hff, 1'b1, K_ERR_CHAR},
    '{OP_BYTE, 8'h80, 1'b1, K_ERR_CHAR},
    '{OP_BYTE, "1",   1'b0, K_NONE},
    '{OP_BYTE, ".",   1'b0, K_NONE},
    '{OP_BYTE, "5",   1'b0, K_NONE},
    '{OP_BYTE, "x",   1'b0, K_NONE},
    '{OP_BYTE, ">",   1'b0, K_NONE},
    '{OP_BYTE, "=",   1'b0, K_NONE},
    '{OP_BYTE, "9",   1'b0, K_NONE},
    '{OP_BYTE, ".",   1'b0, K_NONE},
    '{OP_BYTE, ".",   1'b0, K_NONE},
    '{OP_BYTE, ".",   1'b0, K_NONE},
    '{OP_BYTE, 8'h22, 1'b0, K_NONE},
    '{OP_BYTE, 8'h5c, 1'b0, K_NONE},
    '{OP_BYTE, "n",   1'b0, K_NONE},
    '{OP_BYTE, 8'h5c, 1'b0, K_NONE},
    '{OP_BYTE, "q",   1'b0, K_NONE},
    '{OP_BYTE, 8'h0a, 1'b0, K_NONE},
    '{OP_BYTE, 8'h5c, 1'b0, K_NONE},
    '{OP_END,  8'h00, 1'b0, K_NONE},
    '{OP_BYTE, "#",   1'b0, K_NONE},
    '{OP_BYTE, 8'h0a, 1'b1, K_NEWLINE},
    '{OP_BYTE, "7",   1'b0, K_NONE}
  };

  // compare each output word with the oldest expectation
  always @(posedge clk) begin
    token_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_tdata);
        errors++;
      end else begin
        w = pending_tokens.pop_front();
        if ({out_tdata[109:0], out_tlast} !==
            {w.sbyte, w.line, w.end_off, w.start_off, w.kind, w.last}) begin
          $display("%0t: mismatch exp kind %0d s %0h e %0h ln %0d b %h l %b",
                   $time, w.kind, w.start_off, w.end_off, w.line, w.sbyte, w.last);
          $display("%0t:          act kind %0d s %0h e %0h ln %0d b %h l %b",
                   $time, out_tdata[5:0], out_tdata[37:6], out_tdata[69:38],
                   out_tdata[101:70], out_tdata[109:102], out_tlast);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off counted here
  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      out_tready <= 1'b0;
      if (hold_cnt == 59) hold_done <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end else if (cycles % 64 < 20) out_tready <= 1'b1;
    else out_tready <= $urandom_range(0, 2) != 0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    token_word_t w;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sc_mode = M_IDLE; sc_start = 0; sc_pos = 0; sc_line = 1; sc_held = 0;

    foreach (rows[i]) begin
      send_word(rows[i].op, rows[i].data);
      if (rows[i].has_exp) begin
        w = pending_tokens[pending_tokens.size() - 1];
        if (w.kind != rows[i].exp_kind) begin
          $display("%0t: row %0d exp kind %0d act %0d", $time, i,
                   rows[i].exp_kind, w.kind);
          errors++;
        end
      end
    end
    drain();

    // long receiver hold while the sender keeps offering
    hold_start = 1'b1;
    repeat (20) send_word(OP_BYTE, "(");
    drain();

    repeat (110) send_fragment();
    send_word(OP_END, 8'h00);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_tokens.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/sts_pkg.sv
src/sts_core.sv
src/sts_outq.sv
src/script_token_scanner_unit.sv
sim/testbench.sv
